/* sv/assert_macros.svh */
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("%m: assertion failed");
// Check that an antecedent implies a consequent in the following cycle.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");
`else
`define ASSERT_ALWAYS(label, expr)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* sv/crif_pkg.sv */
// Types, constants and helpers shared by the chain record ID filter.
package crif_pkg;

  localparam int ID_WIDTH_DEFAULT = 64;
  localparam int WANTED_WIDTH     = 64;
  localparam int CFG_INDEX_WIDTH  = 8;

  // Configuration register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_WANTED_ID      = 8'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ID_FIELD_INDEX = 8'd1;

  localparam logic [7:0] FIELD_INDEX_RESET = 8'd12;
  localparam logic [2:0] PREFIX_LEN        = 3'd5;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       line_end;
    logic       keep_line;
    logic       finished;
    logic       found;
  } result_t;

  typedef struct packed {
    logic done;
    logic keeping;
  } core_status_t;

  // Character expected at a position of the header word "chain".
  function automatic logic [7:0] prefix_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = 8'h63;
      3'd1:    ch = 8'h68;
      3'd2:    ch = 8'h61;
      3'd3:    ch = 8'h69;
      3'd4:    ch = 8'h6E;
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

endpackage

/* sv/chain_record_id_filter_top.sv */
// Chain record ID filter: one byte in, one result item out, one item per cycle while out_ready allows.
// The block echoes a text stream byte by byte and marks each line end with a
// keep or drop verdict; a line beginning with "chain" is a header whose field
// at id_field_index is read as a decimal ID (saturating), and a header whose ID
// equals wanted_id starts a kept run that a blank line ends. Items pass
// through an input register and then a result register, so an item is taken
// every cycle unless out_ready stalls the result register; the per-byte
// parse (prefix check, field count, multiply-by-ten accumulate) sits between
// those two registers. Write configuration only while no item is in flight.
module chain_record_id_filter_top import crif_pkg::*; #(
  parameter int ID_WIDTH = ID_WIDTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_byte,
  input  logic                       end_of_input,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 out_byte,
  output logic                       byte_valid,
  output logic                       line_end,
  output logic                       keep_line,
  output logic                       finished,
  output logic                       found,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [WANTED_WIDTH-1:0]    cfg_data
);

`include "assert_macros.svh"

  logic [WANTED_WIDTH-1:0] wanted_id;
  logic [7:0]              id_field_index;
  in_item_t                in_item;
  in_item_t                held_item;
  logic                    held_valid;
  logic                    can_take;
  logic                    advance;
  result_t                 core_result;
  result_t                 out_item;
  core_status_t            status;

  crif_cfg_regs u_cfg (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .wanted_id      (wanted_id),
    .id_field_index (id_field_index)
  );

  assign in_item.in_byte      = in_byte;
  assign in_item.end_of_input = end_of_input;

  crif_in_reg u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .pop      (advance),
    .valid    (held_valid),
    .item     (held_item)
  );

  // Move the held item when the result register has room
  assign advance = held_valid && can_take;

  crif_parse_core #(
    .ID_WIDTH (ID_WIDTH)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .item           (held_item),
    .wanted_id      (wanted_id),
    .id_field_index (id_field_index),
    .result         (core_result),
    .status         (status)
  );

  crif_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (advance),
    .push_item (core_result),
    .can_take  (can_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .item      (out_item)
  );

  assign out_byte   = out_item.out_byte;
  assign byte_valid = out_item.byte_valid;
  assign line_end   = out_item.line_end;
  assign keep_line  = out_item.keep_line;
  assign finished   = out_item.finished;
  assign found      = out_item.found;

  // Once finished, the block stays finished
  `ASSERT_NEXT(a_done_sticky, status.done, status.done)
  // A keep verdict only comes with a line end
  `ASSERT_ALWAYS(a_keep_needs_end, !(out_valid && keep_line && !line_end))
  // Found is only reported together with finished
  `ASSERT_ALWAYS(a_found_needs_finish, !(out_valid && found && !finished))
  // An input item is refused only while one is held
  `ASSERT_ALWAYS(a_ready_when_empty, held_valid || in_ready)

endmodule

/* sv/crif_cfg_regs.sv */
// Configuration registers: wanted ID and ID field index.
module crif_cfg_regs import crif_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [WANTED_WIDTH-1:0]    cfg_data,
  output logic [WANTED_WIDTH-1:0]    wanted_id,
  output logic [7:0]                 id_field_index
);

  // Accept a write every cycle
  assign cfg_ready = 1'b1;

  // Decode the index and update the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      wanted_id      <= '0;
      id_field_index <= FIELD_INDEX_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WANTED_ID:      wanted_id      <= cfg_data;
        REG_ID_FIELD_INDEX: id_field_index <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

/* sv/crif_in_reg.sv */
// Input register holding one accepted item until the parser takes it.
module crif_in_reg import crif_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  logic     pop,
  output logic     valid,
  output in_item_t item
);

  // Take a new item when empty or when the held one leaves this cycle
  assign in_ready = !valid || pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // Load payload with each accepted item
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

/* sv/crif_parse_core.sv */
// Per-byte line parser: header detection, ID field parsing and keep verdict.
module crif_parse_core import crif_pkg::*; #(
  parameter int ID_WIDTH = ID_WIDTH_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    advance,
  input  in_item_t                item,
  input  logic [WANTED_WIDTH-1:0] wanted_id,
  input  logic [7:0]              id_field_index,
  output result_t                 result,
  output core_status_t            status
);

  localparam int SUM_WIDTH = ID_WIDTH + 4;
  localparam logic [ID_WIDTH-1:0] ID_MAX = '1;

  logic [2:0]          line_position,   line_position_next;
  logic                prefix_matching, prefix_matching_next;
  logic                header_line,     header_line_next;
  logic [7:0]          field_count,     field_count_next;
  logic                inside_token,    inside_token_next;
  logic                digits_active,   digits_active_next;
  logic [ID_WIDTH-1:0] parsed_id,       parsed_id_next;
  logic                keeping,         keeping_next;
  logic                done_flag,       done_flag_next;
  logic                digit_seen,      digit_seen_next;
  logic                text_cut,        text_cut_next;

  // Work out the result and next state for the held item
  always_comb begin
    logic [7:0]           c;
    logic [7:0]           digit_full;
    logic [SUM_WIDTH-1:0] ext;
    logic [SUM_WIDTH-1:0] sum;
    logic [2:0]           pos_inc;
    logic                 skip_char;
    logic                 close_line;
    logic                 close_nl;
    logic [ID_WIDTH-1:0]  close_id;

    c          = item.in_byte;
    digit_full = c - CH_ZERO;
    pos_inc    = line_position + 3'd1;
    skip_char  = (c == CH_TAB) || (c == CH_VT) || (c == CH_FF) || (c == CH_CR)
                 || (c == CH_LF);
    close_line = 1'b0;
    close_nl   = 1'b0;
    close_id   = parsed_id;
    ext        = '0;
    sum        = '0;

    result               = '0;
    line_position_next   = line_position;
    prefix_matching_next = prefix_matching;
    header_line_next     = header_line;
    field_count_next     = field_count;
    inside_token_next    = inside_token;
    digits_active_next   = digits_active;
    parsed_id_next       = parsed_id;
    keeping_next         = keeping;
    done_flag_next       = done_flag;
    digit_seen_next      = digit_seen;
    text_cut_next        = text_cut;

    if (done_flag) begin
      // Finished: report only the finish and found flags
      result.finished = 1'b1;
      result.found    = keeping;
    end else if (item.end_of_input) begin
      // Close a pending line without newline, then finish
      if (line_position != 3'd0) begin
        close_line      = 1'b1;
        result.line_end = 1'b1;
      end
      done_flag_next = 1'b1;
    end else begin
      result.out_byte   = c;
      result.byte_valid = 1'b1;
      if (c == CH_LF) begin
        result.line_end = 1'b1;
        if (line_position == 3'd0) begin
          // Blank line: ends a kept run, dropped otherwise
          if (keeping) begin
            result.keep_line = 1'b1;
            result.finished  = 1'b1;
            result.found     = 1'b1;
            done_flag_next   = 1'b1;
          end
        end else begin
          close_line = 1'b1;
          close_nl   = 1'b1;
        end
      end else begin
        // Track the header prefix
        if (line_position < PREFIX_LEN) begin
          if (c != prefix_char(line_position)) begin
            prefix_matching_next = 1'b0;
          end
          line_position_next = pos_inc;
          if (pos_inc == PREFIX_LEN && prefix_matching_next) begin
            header_line_next = 1'b1;
          end
        end
        // Split fields and parse the ID field
        if (!text_cut) begin
          if (c == CH_NUL) begin
            text_cut_next = 1'b1;
          end else if (c == CH_SPACE) begin
            if (inside_token) begin
              inside_token_next = 1'b0;
              field_count_next  = field_count + 8'd1;
            end
            digits_active_next = 1'b0;
          end else begin
            if (!inside_token) begin
              inside_token_next = 1'b1;
              if (field_count == id_field_index) begin
                parsed_id_next     = '0;
                digit_seen_next    = 1'b0;
                digits_active_next = 1'b1;
              end
            end
            if (digits_active_next) begin
              if (c >= CH_ZERO && c <= CH_NINE) begin
                // Multiply by ten and add the digit, saturating
                ext = SUM_WIDTH'(parsed_id_next);
                sum = (ext << 3) + (ext << 1) + SUM_WIDTH'(digit_full[3:0]);
                if (sum[SUM_WIDTH-1:ID_WIDTH] != 4'd0) begin
                  parsed_id_next = ID_MAX;
                end else begin
                  parsed_id_next = sum[ID_WIDTH-1:0];
                end
                digit_seen_next = 1'b1;
              end else if (!(skip_char && !digit_seen_next)) begin
                digits_active_next = 1'b0;
              end
            end
          end
        end
      end
    end

    // Close the line: give the verdict and clear per-line state
    if (close_line) begin
      if (close_nl && !text_cut && !inside_token && field_count == id_field_index) begin
        close_id = '0;
      end
      if (header_line) begin
        keeping_next = (WANTED_WIDTH'(close_id) == wanted_id);
      end
      result.keep_line = keeping_next;
    end
    if (!done_flag && item.end_of_input) begin
      result.finished = 1'b1;
      result.found    = keeping_next;
    end
    if (close_line || (!done_flag && !item.end_of_input && c == CH_LF)) begin
      line_position_next   = 3'd0;
      prefix_matching_next = 1'b1;
      header_line_next     = 1'b0;
      field_count_next     = 8'd0;
      inside_token_next    = 1'b0;
      digits_active_next   = 1'b0;
      parsed_id_next       = '0;
      digit_seen_next      = 1'b0;
      text_cut_next        = 1'b0;
    end
  end

  // Hold parser state; advance it with each item passed on
  always_ff @(posedge clk) begin
    if (rst) begin
      line_position   <= 3'd0;
      prefix_matching <= 1'b1;
      header_line     <= 1'b0;
      field_count     <= 8'd0;
      inside_token    <= 1'b0;
      digits_active   <= 1'b0;
      parsed_id       <= '0;
      keeping         <= 1'b0;
      done_flag       <= 1'b0;
      digit_seen      <= 1'b0;
      text_cut        <= 1'b0;
    end else if (advance) begin
      line_position   <= line_position_next;
      prefix_matching <= prefix_matching_next;
      header_line     <= header_line_next;
      field_count     <= field_count_next;
      inside_token    <= inside_token_next;
      digits_active   <= digits_active_next;
      parsed_id       <= parsed_id_next;
      keeping         <= keeping_next;
      done_flag       <= done_flag_next;
      digit_seen      <= digit_seen_next;
      text_cut        <= text_cut_next;
    end
  end

  assign status.done    = done_flag;
  assign status.keeping = keeping;

endmodule

/* sv/crif_out_reg.sv */
// Result register holding one result item until it is taken.
module crif_out_reg import crif_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_item,
  output logic    can_take,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t item
);

  // Room when empty or when the held item leaves this cycle
  assign can_take = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_take) begin
      out_valid <= push;
    end
  end

  // Load the result with each new item
  always_ff @(posedge clk) begin
    if (push && can_take) begin
      item <= push_item;
    end
  end

endmodule

/* tb/chain_record_id_filter_top_tb.sv */
// Self-checking testbench for the chain record ID filter top level.
module chain_record_id_filter_top_tb;
  import crif_pkg::*;

  localparam logic [63:0] ID_LIMIT = {64{1'b1}} >> (64 - ID_WIDTH_DEFAULT);

  typedef enum {HDR_MATCH, HDR_OTHER, HDR_SHORT, HDR_HUGE, HDR_CUT, HDR_EMPTY_FIELD,
                HDR_WRAP} hdr_kind_t;
  typedef enum {RX_OPEN, RX_HALF, RX_SPARSE} rx_mode_t;

  // Predicts one result item per input item and checks the block's results in order.
  class id_filter_scoreboard;
    logic [63:0] wanted;
    logic [7:0]  field_sel;
    logic [2:0]  line_pos;
    bit          prefix_ok;
    bit          is_header;
    logic [7:0]  field_cnt;
    bit          in_token;
    bit          in_digits;
    logic [63:0] id_val;
    bit          keeping;
    bit          done;
    bit          digit_seen;
    bit          text_cut;
    string       hdr_word = "chain";
    result_t     expected_results[$];
    int          mismatches;

    function new();
      wanted = '0;
      field_sel = FIELD_INDEX_RESET;
      keeping = 1'b0;
      done = 1'b0;
      mismatches = 0;
      clear_line();
    endfunction

    function void clear_line();
      line_pos = '0;
      prefix_ok = 1'b1;
      is_header = 1'b0;
      field_cnt = '0;
      in_token = 1'b0;
      in_digits = 1'b0;
      id_val = '0;
      digit_seen = 1'b0;
      text_cut = 1'b0;
    endfunction

    function void set_reg(logic [7:0] idx, logic [63:0] val);
      if (idx == REG_WANTED_ID) begin
        wanted = val;
      end else if (idx == REG_ID_FIELD_INDEX) begin
        field_sel = val[7:0];
      end
    endfunction

    // Give the verdict for the closing line and start a fresh one
    function bit close_line(bit with_nl);
      bit keep;
      if (with_nl && !text_cut && !in_token && field_cnt == field_sel) id_val = '0;
      if (is_header) keeping = (id_val == wanted);
      keep = keeping;
      clear_line();
      return keep;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Advance the line parser by one accepted item and queue its result
    function void note_input(logic [7:0] c, logic eoi);
      result_t     r;
      logic [63:0] d;
      r = '0;
      if (done) begin
        r.finished = 1'b1;
        r.found = keeping;
      end else if (eoi) begin
        if (line_pos != 0) begin
          r.line_end = 1'b1;
          r.keep_line = close_line(1'b0);
        end
        done = 1'b1;
        r.finished = 1'b1;
        r.found = keeping;
      end else begin
        r.out_byte = c;
        r.byte_valid = 1'b1;
        if (c == CH_LF) begin
          r.line_end = 1'b1;
          if (line_pos == 0) begin
            // blank line: ends a kept run, else just dropped
            r.keep_line = keeping;
            if (keeping) begin
              done = 1'b1;
              r.finished = 1'b1;
              r.found = 1'b1;
            end
            clear_line();
          end else begin
            r.keep_line = close_line(1'b1);
          end
        end else begin
          // track the header word over the first bytes
          if (line_pos < PREFIX_LEN) begin
            if (c != hdr_word[line_pos]) prefix_ok = 1'b0;
            line_pos++;
            if (line_pos == PREFIX_LEN && prefix_ok) is_header = 1'b1;
          end
          if (!text_cut) begin
            if (c == CH_NUL) begin
              text_cut = 1'b1;
            end else if (c == CH_SPACE) begin
              if (in_token) begin
                in_token = 1'b0;
                field_cnt++;
              end
              in_digits = 1'b0;
            end else begin
              if (!in_token) begin
                in_token = 1'b1;
                if (field_cnt == field_sel) begin
                  id_val = '0;
                  digit_seen = 1'b0;
                  in_digits = 1'b1;
                end
              end
              // accumulate the decimal ID, saturating
              if (in_digits) begin
                if (c >= CH_ZERO && c <= CH_NINE) begin
                  d = 64'(c - CH_ZERO);
                  if (id_val > (ID_LIMIT - d) / 64'd10) id_val = ID_LIMIT;
                  else id_val = id_val * 64'd10 + d;
                  digit_seen = 1'b1;
                end else if (!((c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR)
                               && !digit_seen)) begin
                  in_digits = 1'b0;
                end
              end
            end
          end
        end
      end
      expected_results.push_back(r);
    endfunction

    function string show(result_t r);
      return $sformatf("byte=%02h valid=%0b end=%0b keep=%0b finished=%0b found=%0b",
                       r.out_byte, r.byte_valid, r.line_end, r.keep_line, r.finished, r.found);
    endfunction

    function void report(string what, result_t exp, result_t act);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t mismatch: %s: expected %s, got %s", $time, what, show(exp), show(act));
    endfunction

    // Compare an accepted result with the oldest expectation
    function void check_result(result_t act);
      result_t exp;
      if (expected_results.size() == 0) begin
        report("result with nothing expected", '0, act);
        return;
      end
      exp = expected_results.pop_front();
      if (exp.out_byte !== act.out_byte || exp.byte_valid !== act.byte_valid ||
          exp.line_end !== act.line_end || exp.keep_line !== act.keep_line ||
          exp.finished !== act.finished || exp.found !== act.found)
        report("wrong result", exp, act);
    endfunction
  endclass

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [7:0]                 in_byte = '0;
  logic                       end_of_input = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [7:0]                 out_byte;
  logic                       byte_valid;
  logic                       line_end;
  logic                       keep_line;
  logic                       finished;
  logic                       found;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [WANTED_WIDTH-1:0]    cfg_data = '0;

  id_filter_scoreboard sb;
  logic [7:0]          line_buf[$];
  int                  burst_left = 0;
  int                  results_seen = 0;

  chain_record_id_filter_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .line_end     (line_end),
    .keep_line    (keep_line),
    .finished     (finished),
    .found        (found),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Give up after a generous fixed time
  initial begin
    #6000000;
    $display("chain_record_id_filter_top_tb: FAIL");
    $finish;
  end

  // Check every accepted result item
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_result({out_byte, byte_valid, line_end, keep_line, finished, found});
      results_seen++;
    end
  end

  // Stall the result side on a shifting pattern, with two long hold-offs
  initial begin
    rx_mode_t mode;
    int       mode_left;
    int       hold_left;
    bit [1:0] holds_done;
    mode = RX_OPEN;
    mode_left = 0;
    hold_left = 0;
    holds_done = '0;
    forever begin
      @(negedge clk);
      if (!holds_done[0] && results_seen >= 300) begin
        holds_done[0] = 1'b1;
        hold_left = 90;
      end
      if (!holds_done[1] && results_seen >= 1500) begin
        holds_done[1] = 1'b1;
        hold_left = 90;
      end
      if (mode_left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(20, 150);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          RX_OPEN:   out_ready <= 1'b1;
          RX_HALF:   out_ready <= 1'($urandom_range(0, 1));
          default:   out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Offer one item, in bursts with random gaps, and note it once taken
  task automatic send_item(input logic [7:0] b, input logic eoi);
    if (burst_left == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 7)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_byte <= b;
    end_of_input <= eoi;
    do @(posedge clk); while (!in_ready);
    sb.note_input(b, eoi);
    burst_left--;
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_item(line_buf[i], 1'b0);
  endtask

  // Drop valid and wait until every expected result item has come back
  task automatic settle(input int extra);
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  function automatic void put_sep();
    repeat ($urandom_range(1, 3)) line_buf.push_back(CH_SPACE);
  endfunction

  function automatic void put_filler();
    repeat ($urandom_range(1, 4)) line_buf.push_back(8'($urandom_range(8'h21, 8'h7e)));
  endfunction

  // Append a header line whose ID field follows the current field index
  function automatic void build_header(hdr_kind_t kind);
    logic [63:0] id;
    logic [7:0]  j;
    put_str("chain");
    if (kind == HDR_CUT) line_buf.push_back(CH_NUL);
    for (int k = 1; k < int'(sb.field_sel); k++) begin
      put_sep();
      put_filler();
    end
    if (kind == HDR_EMPTY_FIELD) begin
      put_sep();
      line_buf.push_back(CH_LF);
      return;
    end
    if (kind == HDR_SHORT || sb.field_sel == 0) begin
      line_buf.push_back(CH_LF);
      return;
    end
    id = (kind == HDR_MATCH) ? sb.wanted : {$urandom, $urandom};
    if (kind == HDR_OTHER && $urandom_range(0, 1) == 1) id = sb.wanted + 64'd1;
    // place a decoy ID, then the real one 256 fields later
    if (kind == HDR_WRAP) begin
      put_sep();
      put_str($sformatf("%0d", $urandom));
      repeat (255) begin
        line_buf.push_back(CH_SPACE);
        line_buf.push_back(8'($urandom_range(8'h21, 8'h7e)));
      end
      id = sb.wanted;
    end
    put_sep();
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0:       line_buf.push_back(CH_TAB);
        1:       line_buf.push_back(CH_VT);
        2:       line_buf.push_back(CH_FF);
        default: line_buf.push_back(CH_CR);
      endcase
    end
    if ($urandom_range(0, 3) == 0) put_str("00");
    if (kind == HDR_HUGE) begin
      repeat ($urandom_range(20, 24)) line_buf.push_back(CH_NINE);
    end else begin
      put_str($sformatf("%0d", id));
    end
    // end the number on some non-digit
    if ($urandom_range(0, 3) == 0) begin
      do j = 8'($urandom_range(0, 255));
      while ((j >= CH_ZERO && j <= CH_NINE) || j == CH_SPACE || j == CH_LF);
      line_buf.push_back(j);
    end
    repeat ($urandom_range(0, 2)) begin
      put_sep();
      put_filler();
    end
    line_buf.push_back(CH_LF);
  endfunction

  function automatic void build_text(bit noisy);
    logic [7:0] b;
    if (!noisy && $urandom_range(0, 3) == 0) put_str("chai");
    repeat ($urandom_range(1, 24)) begin
      if (noisy) begin
        do b = 8'($urandom_range(0, 255)); while (b == CH_LF);
      end else begin
        case ($urandom_range(0, 3))
          0:       b = CH_SPACE;
          1:       b = 8'($urandom_range(CH_ZERO, CH_NINE));
          default: b = 8'($urandom_range(8'h21, 8'h7e));
        endcase
      end
      line_buf.push_back(b);
    end
    line_buf.push_back(CH_LF);
  endfunction

  // Pick a line; never a blank one while a run is kept
  function automatic void build_random_line();
    int pick;
    pick = $urandom_range(0, 99);
    line_buf.delete();
    if (pick < 30) build_header(HDR_MATCH);
    else if (pick < 42) build_header(HDR_OTHER);
    else if (pick < 46) build_header(HDR_SHORT);
    else if (pick < 50) build_header(HDR_HUGE);
    else if (pick < 54) build_header(HDR_CUT);
    else if (pick < 58) build_header(HDR_EMPTY_FIELD);
    else if (pick < 63 && !sb.keeping) line_buf.push_back(CH_LF);
    else if (pick < 70) build_text(1'b1);
    else build_text(1'b0);
  endfunction

  task automatic run_phase(input logic [63:0] want, input logic [7:0] sel, input int budget,
                           input bit with_wrap);
    int sent;
    sent = 0;
    settle(4);
    write_reg(REG_WANTED_ID, want);
    write_reg(REG_ID_FIELD_INDEX, sel);
    if (with_wrap) begin
      line_buf.delete();
      build_header(HDR_WRAP);
      send_line();
      sent = line_buf.size();
    end
    while (sent < budget) begin
      build_random_line();
      send_line();
      sent += line_buf.size();
    end
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: blank drop, header with skipped tab and leading zero,
    // kept line with zero and all-ones bytes, header missing its field
    write_reg(REG_WANTED_ID, 64'd7);
    write_reg(REG_ID_FIELD_INDEX, 8'd1);
    line_buf.delete();
    line_buf.push_back(CH_LF);
    put_str("chain ");
    line_buf.push_back(CH_TAB);
    put_str("07x");
    line_buf.push_back(CH_LF);
    line_buf.push_back(CH_NUL);
    line_buf.push_back(8'hFF);
    line_buf.push_back(CH_SPACE);
    line_buf.push_back(CH_LF);
    put_str("chain");
    line_buf.push_back(CH_LF);
    send_line();

    // Random phases over several register settings
    run_phase(64'($urandom_range(0, 999)), FIELD_INDEX_RESET, 200, 1'b0);
    run_phase(64'd0, 8'd0, 200, 1'b0);
    run_phase(ID_LIMIT, 8'd3, 200, 1'b0);
    run_phase({$urandom, $urandom}, 8'd2, 150, 1'b1);
    run_phase(64'($urandom), 8'd40, 200, 1'b0);
    run_phase(64'd0, 8'd1, 150, 1'b0);
    run_phase({$urandom, $urandom}, 8'($urandom_range(1, 6)), 150, 1'b0);

    // Finish by a blank line in a kept run, or by end of input
    if ($urandom_range(0, 1) == 1) begin
      if (!sb.keeping) begin
        line_buf.delete();
        build_header(HDR_MATCH);
        send_line();
      end
      line_buf.delete();
      line_buf.push_back(CH_LF);
      send_line();
    end else begin
      build_random_line();
      void'(line_buf.pop_back());
      send_line();
      send_item(8'($urandom_range(0, 255)), 1'b1);
    end
    // Items after finish
    repeat (6) send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

    settle(10);
    if (sb.mismatches == 0) begin
      $display("chain_record_id_filter_top_tb: PASS");
    end else begin
      $display("chain_record_id_filter_top_tb: FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/crif_pkg.sv
sv/crif_cfg_regs.sv
sv/crif_in_reg.sv
sv/crif_parse_core.sv
sv/crif_out_reg.sv
sv/chain_record_id_filter_top.sv
tb/chain_record_id_filter_top_tb.sv
